/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the text-to-panel byte stream.
// Needs signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define CHK_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/ttpbs_pkg.sv */
// Shared types, constants and helpers for the text-to-panel byte stream.
// No dependencies.
package ttpbs_pkg;

	typedef enum logic [1:0] {
		CMD_DRAW = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_HOME = 2'd2
	} cmd_t;

	localparam int SLOT_COUNT   = 96;
	localparam int SLOT_W       = 7;
	localparam int COL_W        = 3;
	localparam int GLYPH_ADDR_W = SLOT_W + COL_W;
	localparam int GLYPH_DEPTH  = SLOT_COUNT << COL_W;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam int         QMARK_CODE   = 63;
	localparam logic [7:0] BLANK_BYTE   = 8'h00;

	typedef enum logic [1:0] {
		CUR_PAGE    = 2'd0,
		CUR_COL_LOW = 2'd1,
		CUR_COL_HI  = 2'd2
	} cur_sel_t;

	// One of the three cursor command bytes for a given page and column.
	function automatic logic [7:0] cursor_byte(input logic [1:0] sel,
		input logic [2:0] page, input logic [7:0] col);
		logic [7:0] b;
		case (cur_sel_t'(sel))
			CUR_PAGE:    b = {5'b10110, page};
			CUR_COL_LOW: b = {4'h0, col[3:0]};
			CUR_COL_HI:  b = {4'h1, col[7:4]};
			default:     b = {4'h1, col[7:4]};
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/ttpbs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ttpbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/text_to_panel_byte_stream.sv */
// A drawing word's first byte passes the position register, stage one and stage
// two before it is offered. Throughput: one panel byte per cycle while out_ready
// holds; a character gives GLYPH_COLUMNS + 4 bytes, + 7 on a wrap; newline and home
// give 3; a load none. The sequencer and single glyph read port set these figures.
// Reset clears the cursor and the pipeline; the glyph memory is not cleared.
// Depends on ttpbs_pkg, ttpbs_ram and assert_macros.svh.
`include "assert_macros.svh"

module text_to_panel_byte_stream
	import ttpbs_pkg::*;
#(
	parameter int LINE_WIDTH    = 128,
	parameter int PAGE_COUNT    = 8,
	parameter int GLYPH_COLUMNS = 5,
	parameter int FIRST_CODE    = 32,
	parameter int LAST_CODE     = 126
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [6:0] glyph_slot,
	input  logic [2:0] glyph_column,
	input  logic [7:0] column_bits,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] panel_byte,
	output logic       is_data,
	output logic       last
);

	localparam logic [3:0] POS_GLYPH  = 4'd3;
	localparam logic [3:0] POS_SPACER = 4'(3 + GLYPH_COLUMNS);
	localparam logic [3:0] POS_END    = 4'(4 + GLYPH_COLUMNS);
	localparam logic [3:0] POS_LAST   = 4'(6 + GLYPH_COLUMNS);
	localparam bit QMARK_OK = (QMARK_CODE >= FIRST_CODE) && (QMARK_CODE <= LAST_CODE) &&
		(QMARK_CODE < FIRST_CODE + SLOT_COUNT);
	localparam logic [SLOT_W-1:0] QMARK_SLOT = SLOT_W'(QMARK_CODE - FIRST_CODE);

	logic             busy_q;
	logic [3:0]       pos_q;
	logic [2:0]       page_q;
	logic [7:0]       endcol_q;
	logic [SLOT_W-1:0] slot_q;
	logic             have_q;
	logic [2:0]       line_page_q;
	logic [6:0]       cur_col_q;

	logic       s1_valid;
	logic [7:0] byte_s1;
	logic       is_data_s1;
	logic       last_s1;
	logic       use_ram_s1;

	logic [7:0] byte_s2;
	logic       is_data_s2;
	logic       last_s2;
	logic       valid_s2;

	logic s2_free, s1_free, issue, accept;
	logic code_ok, load_ok, wrap, is_glyph;
	logic [2:0] page_next;
	logic [7:0] newcol;
	logic [SLOT_W-1:0] char_slot;
	logic [7:0] d_byte;
	logic       d_is_data;
	logic [3:0] col_off;
	logic [3:0] sel_off;
	logic [7:0] ram_rdata;
	logic       ram_we;
	logic       ram_re;

	assign s2_free  = !valid_s2 || out_ready;
	assign s1_free  = !s1_valid || s2_free;
	assign issue    = busy_q && s1_free;
	assign in_ready = !busy_q || (issue && pos_q == POS_LAST);
	assign accept   = in_valid && in_ready;

	assign code_ok = (9'(char_code) >= 9'(FIRST_CODE)) && (9'(char_code) <= 9'(LAST_CODE)) &&
		(9'(char_code) < 9'(FIRST_CODE + SLOT_COUNT));
	assign char_slot = code_ok ? SLOT_W'(9'(char_code) - 9'(FIRST_CODE)) : QMARK_SLOT;
	assign load_ok = (9'(glyph_slot) + 9'(FIRST_CODE) <= 9'(LAST_CODE)) &&
		(8'(glyph_slot) < 8'(SLOT_COUNT)) && (4'(glyph_column) < 4'(GLYPH_COLUMNS));
	assign page_next = (line_page_q == 3'(PAGE_COUNT - 1)) ? 3'd0 : line_page_q + 3'd1;
	assign wrap = (8'(cur_col_q) + 8'(GLYPH_COLUMNS + 1)) > 8'(LINE_WIDTH);
	assign newcol = (wrap ? 8'd0 : 8'(cur_col_q)) + 8'(GLYPH_COLUMNS + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			line_page_q <= '0;
			cur_col_q   <= '0;
		end else begin
			if (accept) begin
				case (cmd_t'(cmd))
					CMD_DRAW: begin
						busy_q <= 1'b1;
						if (char_code == NEWLINE_CODE) begin
							pos_q       <= POS_END;
							line_page_q <= page_next;
							cur_col_q   <= '0;
						end else begin
							pos_q       <= wrap ? 4'd0 : POS_GLYPH;
							line_page_q <= wrap ? page_next : line_page_q;
							cur_col_q   <= (newcol > 8'd127) ? 7'd127 : newcol[6:0];
						end
					end
					CMD_HOME: begin
						busy_q      <= 1'b1;
						pos_q       <= POS_END;
						line_page_q <= '0;
						cur_col_q   <= '0;
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end else if (issue) begin
				pos_q <= pos_q + 4'd1;
				if (pos_q == POS_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (cmd_t'(cmd))
				CMD_DRAW: begin
					if (char_code == NEWLINE_CODE) begin
						page_q   <= page_next;
						endcol_q <= '0;
					end else begin
						page_q   <= wrap ? page_next : line_page_q;
						endcol_q <= newcol;
					end
					slot_q <= char_slot;
					have_q <= code_ok || QMARK_OK;
				end
				CMD_HOME: begin
					page_q   <= '0;
					endcol_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign col_off  = pos_q - POS_GLYPH;
	assign sel_off  = pos_q - POS_END;
	assign is_glyph = (pos_q >= POS_GLYPH) && (pos_q < POS_SPACER);

	always_comb begin
		d_byte    = BLANK_BYTE;
		d_is_data = 1'b1;
		if (pos_q < POS_GLYPH) begin
			d_byte    = cursor_byte(pos_q[1:0], page_q, 8'd0);
			d_is_data = 1'b0;
		end else if (pos_q > POS_SPACER) begin
			d_byte    = cursor_byte(sel_off[1:0], page_q, endcol_q);
			d_is_data = 1'b0;
		end
	end

	assign ram_we = accept && (cmd_t'(cmd) == CMD_LOAD) && load_ok;
	assign ram_re = issue && is_glyph && have_q;

	ttpbs_ram #(
		.WIDTH (8),
		.DEPTH (GLYPH_DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({glyph_slot, glyph_column}),
		.wdata (column_bits),
		.re    (ram_re),
		.raddr ({slot_q, col_off[COL_W-1:0]}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid <= issue;
			end
			if (s2_free) begin
				valid_s2 <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			byte_s1    <= d_byte;
			is_data_s1 <= d_is_data;
			last_s1    <= (pos_q == POS_LAST);
			use_ram_s1 <= is_glyph && have_q;
		end
		if (s2_free && s1_valid) begin
			byte_s2    <= use_ram_s1 ? ram_rdata : byte_s1;
			is_data_s2 <= is_data_s1;
			last_s2    <= last_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign panel_byte = byte_s2;
	assign is_data    = is_data_s2;
	assign last       = last_s2;

	`CHK_ASSERT(a_s1_holds, s1_valid && !s2_free |=> s1_valid && $stable(byte_s1), "stalled stage one word lost")
	`CHK_ASSERT(a_pos_range, busy_q |-> pos_q <= POS_LAST, "sequencer position beyond final byte")
	`CHK_NEVER(a_last_is_cmd, valid_s2 && last_s2 && is_data_s2, "final word is not a command byte")
	`CHK_ASSERT(a_ready_busy, busy_q && in_ready |-> issue && pos_q == POS_LAST, "input taken mid item")

endmodule
